@@ hw/rtl/srtu_pkg.sv @@
package srtu_pkg;

   // field widths of the request and response
   localparam int NODE_W     = 4;
   localparam int COST_W     = 32;
   localparam int EDGE_W     = 20;
   localparam int TAG_W      = 8;
   localparam int OVERHEAD_W = 16;

   // number of nodes that a node field can name
   localparam int NODE_SPAN = 1 << NODE_W;

   localparam logic [COST_W-1:0]     COST_INF       = '1;
   localparam logic [OVERHEAD_W-1:0] OVERHEAD_RESET = 16'd80;

   // request operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   typedef struct packed {
      logic              operation;
      logic [NODE_W-1:0] source_node;
      logic [NODE_W-1:0] dest_node;
      logic [EDGE_W-1:0] edge_cost;
      logic [TAG_W-1:0]  edge_tag;
   } req_type;

   typedef struct packed {
      logic              route_found;
      logic [COST_W-1:0] route_cost;
      logic [NODE_W-1:0] next_node;
      logic [TAG_W-1:0]  first_edge_tag;
      logic              is_identity;
      logic              bad_node;
   } rsp_type;

   // row-stream token handed from cell to cell
   typedef struct packed {
      logic              valid;
      logic [NODE_W-1:0] col;
      logic [COST_W-1:0] cost;
   } tok_type;

   // controls broadcast from the sequencer to every cell
   typedef struct packed {
      logic              clr_en;
      logic [NODE_W-1:0] clr_addr;
      logic              rd_en;
      logic [NODE_W-1:0] rd_addr;
      logic              col_cap;
      logic [NODE_W-1:0] src_node;
      logic [NODE_W-1:0] dst_node;
      logic [COST_W-1:0] edge_total;
      logic [TAG_W-1:0]  tag;
   } cell_ctl_type;

   // registered read data of one cell
   typedef struct packed {
      logic [COST_W-1:0] cost;
      logic [NODE_W-1:0] hop;
      logic [TAG_W-1:0]  tag;
   } cell_rd_type;

endpackage

@@ hw/rtl/shortest_route_table_update_top.sv @@
// channel    ports                                  moves
// request    req_valid / req_ready / req_data       insert edge or lookup route
// response   rsp_valid / rsp_ready / rsp_data       one response per request
// csr        csr_write_enable / csr_write_data      call overhead, no handshake
//
// N = min(NODE_COUNT, 16) row cells. In an insert, the row of the edge end is
// streamed into the chain, and the token then passes each cell's read stage
// and then its compare-and-write stage.
// A lookup passes read, capture and emit states; a request with a bad node goes straight to emit.
// After reset the cost rows are cleared with req_ready low.
// One request is in work at a time; a finished response waits in its own
// register, so the next request is taken while rsp_ready is low.
module shortest_route_table_update_top #(
   parameter int NODE_COUNT = 16,
   parameter int TAG_BITS   = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  srtu_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output srtu_pkg::rsp_type               rsp_data,
   input  logic                            csr_write_enable,
   input  logic [srtu_pkg::OVERHEAD_W-1:0] csr_write_data
);
   import srtu_pkg::*;

   // nodes past the node field's reach stay isolated, so no row is kept for them
   localparam int ROWS = (NODE_COUNT < NODE_SPAN) ? NODE_COUNT : NODE_SPAN;

   cell_ctl_type cell_ctl;
   tok_type      chain   [ROWS+1];
   cell_rd_type  cell_rd [ROWS];

   // sequencer and response
   srtu_ctrl #(
      .NODE_COUNT (NODE_COUNT),
      .ROWS       (ROWS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cell_ctl         (cell_ctl),
      .head_tok         (chain[0]),
      .tail_tok         (chain[ROWS]),
      .cell_rd          (cell_rd)
   );

   // chain of row cells, token passed from each cell to the next
   for (genvar k = 0; k < ROWS; k++) begin : g_cell
      srtu_cell #(
         .ROWS      (ROWS),
         .ROW_INDEX (k),
         .TAG_BITS  (TAG_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (cell_ctl),
         .prev_tok (chain[k]),
         .next_tok (chain[k+1]),
         .row_data (cell_rd[k])
      );
   end

endmodule

@@ hw/rtl/srtu_cell.sv @@
module srtu_cell #(
   parameter int ROWS      = 16,
   parameter int ROW_INDEX = 0,
   parameter int TAG_BITS  = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  srtu_pkg::cell_ctl_type ctl,
   input  srtu_pkg::tok_type      prev_tok,
   output srtu_pkg::tok_type      next_tok,
   output srtu_pkg::cell_rd_type  row_data
);
   import srtu_pkg::*;

   localparam int ROW_BITS = $clog2(ROWS);
   localparam int TAG_KEEP = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

   // one row of the route table: costs, next hops and first-edge tags
   logic [COST_W-1:0]   cost_mem [ROWS];
   logic [NODE_W-1:0]   hop_mem  [ROWS];
   logic [TAG_KEEP-1:0] tag_mem  [ROWS];

   tok_type             tok_ff;
   tok_type             tok2_ff;
   logic [COST_W-1:0]   cur_cost_ff;
   logic [COST_W-1:0]   rd_cost_ff;
   logic [NODE_W-1:0]   rd_hop_ff;
   logic [TAG_KEEP-1:0] rd_tag_ff;
   logic [COST_W-1:0]   a_cost_ff;
   logic [COST_W-1:0]   a_cost_in;
   logic [NODE_W-1:0]   a_hop_ff;
   logic [NODE_W-1:0]   a_hop_in;
   logic [TAG_KEEP-1:0] a_tag_ff;
   logic [TAG_KEEP-1:0] a_tag_in;
   logic [COST_W:0]     col_sum;
   logic [COST_W:0]     cand_sum;
   logic [COST_W-1:0]   cand;
   logic                is_src;
   logic                upd;
   logic [ROW_BITS-1:0] upd_addr;
   logic [ROW_BITS-1:0] tok_addr;
   logic [ROW_BITS-1:0] rd_addr;
   logic [ROW_BITS-1:0] clr_addr;

   assign upd_addr = tok2_ff.col[ROW_BITS-1:0];
   assign tok_addr = tok_ff.col[ROW_BITS-1:0];
   assign rd_addr  = ctl.rd_addr[ROW_BITS-1:0];
   assign clr_addr = ctl.clr_addr[ROW_BITS-1:0];

   // cost of this row to the edge source plus the edge, saturating
   assign col_sum   = {1'b0, rd_cost_ff} + {1'b0, ctl.edge_total};
   assign a_cost_in = col_sum[COST_W] ? COST_INF : col_sum[COST_W-1:0];
   assign is_src    = ctl.src_node == NODE_W'(ROW_INDEX);
   assign a_hop_in  = is_src ? ctl.dst_node : rd_hop_ff;
   assign a_tag_in  = is_src ? TAG_KEEP'(ctl.tag) : rd_tag_ff;

   // detour candidate for the column carried by the token
   assign cand_sum = {1'b0, a_cost_ff} + {1'b0, tok2_ff.cost};
   assign cand     = cand_sum[COST_W] ? COST_INF : cand_sum[COST_W-1:0];
   assign upd      = tok2_ff.valid && (cand < cur_cost_ff);

   // token pipeline: fetch current entry, then compare and write
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid  <= 1'b0;
         tok2_ff.valid <= 1'b0;
      end else begin
         tok_ff  <= prev_tok;
         tok2_ff <= tok_ff;
      end
   end

   // capture the column of the edge source
   always_ff @(posedge clock) begin
      if (ctl.col_cap) begin
         a_cost_ff <= a_cost_in;
         a_hop_ff  <= a_hop_in;
         a_tag_ff  <= a_tag_in;
      end
   end

   // row memory: one write port, token read port, broadcast read port
   always_ff @(posedge clock) begin
      if (ctl.clr_en) begin
         cost_mem[clr_addr] <= (ctl.clr_addr == NODE_W'(ROW_INDEX)) ? '0 : COST_INF;
      end else if (upd) begin
         cost_mem[upd_addr] <= cand;
      end
      if (upd) begin
         hop_mem[upd_addr] <= a_hop_ff;
         tag_mem[upd_addr] <= a_tag_ff;
      end
      cur_cost_ff <= cost_mem[tok_addr];
      if (ctl.rd_en) begin
         rd_cost_ff <= cost_mem[rd_addr];
         rd_hop_ff  <= hop_mem[rd_addr];
         rd_tag_ff  <= tag_mem[rd_addr];
      end
   end

   assign next_tok      = tok2_ff;
   assign row_data.cost = rd_cost_ff;
   assign row_data.hop  = rd_hop_ff;
   assign row_data.tag  = TAG_W'(rd_tag_ff);

endmodule

@@ hw/rtl/srtu_ctrl.sv @@
module srtu_ctrl #(
   parameter int NODE_COUNT = 16,
   parameter int ROWS       = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  srtu_pkg::req_type                       req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output srtu_pkg::rsp_type                       rsp_data,
   input  logic                                    csr_write_enable,
   input  logic [srtu_pkg::OVERHEAD_W-1:0]         csr_write_data,
   output srtu_pkg::cell_ctl_type                  cell_ctl,
   output srtu_pkg::tok_type                       head_tok,
   input  srtu_pkg::tok_type                       tail_tok,
   input  srtu_pkg::cell_rd_type                   cell_rd [ROWS]
);
   import srtu_pkg::*;

   localparam int ROW_BITS = $clog2(ROWS);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_COL_RD,
      ST_COL_CAP,
      ST_ROW,
      ST_DRAIN,
      ST_LK_RD,
      ST_LK_CAP,
      ST_EMIT
   } state_type;

   state_type               state_ff;
   logic [ROW_BITS-1:0]     cnt_ff;
   req_type                 item_ff;
   rsp_type                 res_ff;
   rsp_type                 rsp_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [OVERHEAD_W-1:0]   overhead_ff;
   logic                    head_vld_ff;
   logic [ROW_BITS-1:0]     head_col_ff;

   logic                    req_bad;
   logic                    cnt_last;
   logic                    tail_last;
   logic                    rsp_free;
   logic [NODE_W-1:0]       sel_node;
   cell_rd_type             sel_rd;
   rsp_type                 bad_res;
   rsp_type                 lk_res;

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // response stays valid until taken, and is loaded from the emit state
   assign rsp_valid_in = (state_ff == ST_EMIT) || (rsp_valid_ff && !rsp_ready);

   assign req_bad = (int'(req_data.source_node) >= NODE_COUNT) ||
                    (int'(req_data.dest_node) >= NODE_COUNT);
   assign cnt_last  = cnt_ff == ROW_BITS'(ROWS - 1);
   assign tail_last = tail_tok.valid && (tail_tok.col == NODE_W'(ROWS - 1));

   // pick one cell's read data: the route source for lookups, else the edge end
   assign sel_node = (state_ff == ST_LK_CAP) ? item_ff.source_node : item_ff.dest_node;
   assign sel_rd   = cell_rd[sel_node[ROW_BITS-1:0]];

   // head of the row stream feeding the first cell
   assign head_tok.valid = head_vld_ff;
   assign head_tok.col   = NODE_W'(head_col_ff);
   assign head_tok.cost  = sel_rd.cost;

   // response for a request naming a node out of range
   always_comb begin
      bad_res          = '0;
      bad_res.bad_node = 1'b1;
      if (req_data.operation == OP_LOOKUP) begin
         bad_res.route_cost = COST_INF;
      end
   end

   // lookup response from the selected entry
   always_comb begin
      lk_res            = '0;
      lk_res.route_cost = sel_rd.cost;
      if (item_ff.source_node == item_ff.dest_node) begin
         lk_res.route_found = 1'b1;
         lk_res.next_node   = item_ff.source_node;
         lk_res.is_identity = 1'b1;
      end else if (sel_rd.cost != COST_INF) begin
         lk_res.route_found    = 1'b1;
         lk_res.next_node      = sel_rd.hop;
         lk_res.first_edge_tag = sel_rd.tag;
      end
   end

   // broadcast controls to the cells
   always_comb begin
      cell_ctl            = '0;
      cell_ctl.src_node   = item_ff.source_node;
      cell_ctl.dst_node   = item_ff.dest_node;
      cell_ctl.tag        = item_ff.edge_tag;
      cell_ctl.edge_total = COST_W'(item_ff.edge_cost) + COST_W'(overhead_ff);
      case (state_ff)
         ST_CLEAR: begin
            cell_ctl.clr_en   = 1'b1;
            cell_ctl.clr_addr = NODE_W'(cnt_ff);
         end
         ST_COL_RD: begin
            cell_ctl.rd_en   = 1'b1;
            cell_ctl.rd_addr = item_ff.source_node;
         end
         ST_COL_CAP: begin
            cell_ctl.col_cap = 1'b1;
         end
         ST_ROW: begin
            cell_ctl.rd_en   = 1'b1;
            cell_ctl.rd_addr = NODE_W'(cnt_ff);
         end
         ST_LK_RD: begin
            cell_ctl.rd_en   = 1'b1;
            cell_ctl.rd_addr = item_ff.dest_node;
         end
         default: begin
         end
      endcase
   end

   // sequencer, overhead register and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         head_vld_ff  <= 1'b0;
         overhead_ff  <= OVERHEAD_RESET;
      end else begin
         if (csr_write_enable) begin
            overhead_ff <= csr_write_data;
         end
         head_vld_ff  <= state_ff == ST_ROW;
         head_col_ff  <= cnt_ff;
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            ST_CLEAR: begin
               if (cnt_last) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_IDLE;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  item_ff <= req_data;
                  if (req_bad) begin
                     res_ff   <= bad_res;
                     state_ff <= ST_EMIT;
                  end else if (req_data.operation == OP_LOOKUP) begin
                     state_ff <= ST_LK_RD;
                  end else begin
                     state_ff <= ST_COL_RD;
                  end
               end
            end
            ST_COL_RD: begin
               state_ff <= ST_COL_CAP;
            end
            ST_COL_CAP: begin
               cnt_ff   <= '0;
               state_ff <= ST_ROW;
            end
            ST_ROW: begin
               if (cnt_last) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_DRAIN;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_DRAIN: begin
               if (tail_last) begin
                  res_ff   <= '0;
                  state_ff <= ST_EMIT;
               end
            end
            ST_LK_RD: begin
               state_ff <= ST_LK_CAP;
            end
            ST_LK_CAP: begin
               res_ff   <= lk_res;
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (rsp_free) begin
                  rsp_ff   <= res_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_CLEAR;
            end
         endcase
      end
   end

endmodule
